### rtl/hca_pkg.sv
package hca_pkg;

   localparam int TIME_BITS     = 32;
   localparam int DEADLINE_BITS = TIME_BITS + 1;
   localparam int NOW_BITS      = 32;
   localparam int CFG_BITS      = 16;
   localparam int CSR_IDX_BITS  = 1;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_BITS-1:0] INITIAL_DELAY_RESET = CFG_BITS'(350);
   localparam logic [CFG_BITS-1:0] REPEAT_INTERVAL_RESET = CFG_BITS'(80);

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_SHOT = 2'd1,
      EV_UP   = 2'd2,
      EV_DOWN = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INITIAL_DELAY   = 1'b0,
      CSR_REPEAT_INTERVAL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] initial_delay;
      logic [CFG_BITS-1:0] repeat_interval;
   } cfg_type;

   typedef struct packed {
      logic                 shot_chord;
      logic                 shot_ok;
      logic                 scroll_chord;
      dir_type              dir;
      logic [TIME_BITS-1:0] now;
   } cls_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } queue_stat_type;

   typedef struct packed {
      logic    baseline;
      logic    scroll_prev;
      logic    armed;
      dir_type held_dir;
      logic    deadline_zero;
   } back_stat_type;

   function automatic event_type dir_event(input dir_type dir);
      event_type ev;
      unique case (dir)
         DIR_UP:   ev = EV_UP;
         DIR_DOWN: ev = EV_DOWN;
         default:  ev = EV_NONE;
      endcase
      return ev;
   endfunction

endpackage

### rtl/hca_if.sv
interface hca_req_if;
   import hca_pkg::*;
   logic                valid;
   logic                ready;
   logic                fn_key;
   logic                shift_key;
   logic                command_key;
   logic                control_key;
   logic                option_key;
   logic                up_key;
   logic                down_key;
   logic [NOW_BITS-1:0] now_ms;

   modport source (output valid, fn_key, shift_key, command_key, control_key, option_key,
                   up_key, down_key, now_ms, input ready);
   modport sink (input valid, fn_key, shift_key, command_key, control_key, option_key,
                 up_key, down_key, now_ms, output ready);
endinterface

interface hca_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_code;

   modport source (output valid, event_code, input ready);
   modport sink (input valid, event_code, output ready);
endinterface

### rtl/hca_front.sv
module hca_front (
   hca_req_if.sink           req_ch,
   input  logic              queue_full,
   output logic              push,
   output hca_pkg::cls_type  push_data
);
   import hca_pkg::*;

   logic blocked;
   logic shot_chord;
   logic scroll_chord;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   assign blocked      = req_ch.command_key || req_ch.control_key || req_ch.option_key;
   assign shot_chord   = req_ch.fn_key && req_ch.shift_key;
   assign scroll_chord = req_ch.fn_key && (req_ch.up_key || req_ch.down_key);

   always_comb begin
      push_data.shot_chord   = shot_chord;
      push_data.shot_ok      = shot_chord && !blocked && !req_ch.up_key && !req_ch.down_key;
      push_data.scroll_chord = scroll_chord;
      push_data.now          = req_ch.now_ms[TIME_BITS-1:0];
      if (scroll_chord && !blocked && !req_ch.shift_key && (req_ch.up_key != req_ch.down_key)) begin
         push_data.dir = req_ch.up_key ? DIR_UP : DIR_DOWN;
      end else begin
         push_data.dir = DIR_NONE;
      end
   end
endmodule

### rtl/hca_queue.sv
module hca_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hca_pkg::cls_type        push_data,
   input  logic                    pop,
   output hca_pkg::cls_type        pop_data,
   output hca_pkg::queue_stat_type stat
);
   import hca_pkg::*;

   cls_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] ptr);
      logic [QPTR_BITS-1:0] nxt;
      if (ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + QPTR_BITS'(1);
      end
      return nxt;
   endfunction

   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

### rtl/hca_back.sv
module hca_back (
   input  logic                   clock,
   input  logic                   reset,
   input  hca_pkg::cfg_type       cfg,
   input  logic                   queue_empty,
   input  hca_pkg::cls_type       pop_data,
   output logic                   pop,
   hca_rsp_if.source              rsp_ch,
   output hca_pkg::back_stat_type stat
);
   import hca_pkg::*;

   logic                     baseline_ff, baseline_in;
   logic                     shot_prev_ff, shot_prev_in;
   logic                     scroll_prev_ff, scroll_prev_in;
   logic                     armed_ff, armed_in;
   dir_type                  held_dir_ff, held_dir_in;
   logic [DEADLINE_BITS-1:0] deadline_ff, deadline_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   event_type                event_ff, event_in;

   logic [DEADLINE_BITS-1:0] now_wide;
   logic                     due;

   assign pop      = !queue_empty && (!rsp_valid_ff || rsp_ch.ready);
   assign now_wide = {1'b0, pop_data.now};
   assign due      = (now_wide >= deadline_ff);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.event_code = event_ff;

   assign stat.baseline      = baseline_ff;
   assign stat.scroll_prev   = scroll_prev_ff;
   assign stat.armed         = armed_ff;
   assign stat.held_dir      = held_dir_ff;
   assign stat.deadline_zero = (deadline_ff == '0);

   always_comb begin
      baseline_in    = baseline_ff;
      shot_prev_in   = shot_prev_ff;
      scroll_prev_in = scroll_prev_ff;
      armed_in       = armed_ff;
      held_dir_in    = held_dir_ff;
      deadline_in    = deadline_ff;
      event_in       = event_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      if (pop) begin
         rsp_valid_in   = 1'b1;
         event_in       = EV_NONE;
         baseline_in    = 1'b1;
         shot_prev_in   = pop_data.shot_chord;
         scroll_prev_in = pop_data.scroll_chord;
         if (baseline_ff && pop_data.shot_chord && !shot_prev_ff && pop_data.shot_ok) begin
            event_in = EV_SHOT;
         end
         priority if (!baseline_ff) begin
            armed_in = 1'b0;
         end else if (pop_data.scroll_chord && !scroll_prev_ff) begin
            if (pop_data.dir != DIR_NONE) begin
               armed_in    = 1'b1;
               held_dir_in = pop_data.dir;
               deadline_in = now_wide + DEADLINE_BITS'(cfg.initial_delay);
               event_in    = dir_event(pop_data.dir);
            end else begin
               armed_in = 1'b0;
            end
         end else if (!pop_data.scroll_chord) begin
            armed_in    = 1'b0;
            held_dir_in = DIR_NONE;
            deadline_in = '0;
         end else if (armed_ff) begin
            if (pop_data.dir != held_dir_ff) begin
               armed_in = 1'b0;
            end else if (due) begin
               deadline_in = now_wide + DEADLINE_BITS'(cfg.repeat_interval);
               event_in    = dir_event(pop_data.dir);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff    <= 1'b0;
         shot_prev_ff   <= 1'b0;
         scroll_prev_ff <= 1'b0;
         armed_ff       <= 1'b0;
         held_dir_ff    <= DIR_NONE;
         deadline_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         baseline_ff    <= baseline_in;
         shot_prev_ff   <= shot_prev_in;
         scroll_prev_ff <= scroll_prev_in;
         armed_ff       <= armed_in;
         held_dir_ff    <= held_dir_in;
         deadline_ff    <= deadline_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
   end
endmodule

### rtl/hotkey_chord_autorepeat_top.sv
// Key chord detector with auto-repeat. Each request is one poll of the keys with a
// millisecond timestamp, and each gives exactly one response with an event code (none,
// screenshot, scroll up, scroll down). While responses are taken, the block sustains one
// request per clock: the front classifies a poll in the cycle it is accepted and writes it
// to a two-entry queue, the back pops one entry per cycle, updates the chord and repeat
// state with one add and one compare, and registers the response. While a response waits,
// the queue keeps taking requests until both entries fill. The delay and interval registers
// are to be written through the csr port while no poll is in flight; the block does not enforce it.
module hotkey_chord_autorepeat_top (
   input  logic                                     clock,
   input  logic                                     reset,
   hca_req_if.sink                                  req_ch,
   hca_rsp_if.source                                rsp_ch,
   input  logic                                     csr_wr_en,
   input  logic [hca_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [hca_pkg::CFG_BITS-1:0]             csr_wr_data
);
   import hca_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           push;
   logic           pop;
   cls_type        push_data;
   cls_type        pop_data;
   queue_stat_type q_stat;
   back_stat_type  b_stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INITIAL_DELAY:   cfg_in.initial_delay   = csr_wr_data;
            CSR_REPEAT_INTERVAL: cfg_in.repeat_interval = csr_wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_delay   <= INITIAL_DELAY_RESET;
         cfg_ff.repeat_interval <= REPEAT_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hca_front u_front (
      .req_ch     (req_ch),
      .queue_full (q_stat.full),
      .push       (push),
      .push_data  (push_data)
   );

   hca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   hca_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (q_stat.empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_ch      (rsp_ch),
      .stat        (b_stat)
   );

`ifndef SYNTHESIS
   a_armed_has_dir: assert property (@(posedge clock) disable iff (reset)
      b_stat.armed |-> (b_stat.held_dir != DIR_NONE))
      else $error("repeat armed without a held direction");

   a_released_disarmed: assert property (@(posedge clock) disable iff (reset)
      (!b_stat.baseline || !b_stat.scroll_prev) |-> !b_stat.armed)
      else $error("repeat armed while scroll chord released");

   a_no_dir_no_deadline: assert property (@(posedge clock) disable iff (reset)
      (b_stat.held_dir == DIR_NONE) |-> b_stat.deadline_zero)
      else $error("deadline kept without a held direction");

   a_queue_bounded: assert property (@(posedge clock) disable iff (reset)
      (q_stat.full && !pop) |=> !push)
      else $error("request taken into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif
endmodule
